// File: src/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Attribute after reset: light grey on black
  localparam logic [7:0] ATTR_RESET = 8'h07;

  // Control bytes
  localparam logic [7:0] CH_LINE_FEED = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Request kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [10:0] read_index;
  } in_req_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic        cell_written;
    logic [10:0] write_index;
    logic [15:0] write_entry;
    logic        scrolled;
    logic [15:0] read_data;
  } out_resp_t;

endpackage

// File: src/tcw_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/text_console_writer.sv
// Text console writer: cursor control and screen cell store.
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_write            cfg_data (colour attribute)
//   in        in         in_valid / in_ready  in_req  (tcw_pkg::in_req_t)
//   out       out        out_valid / out_ready out_resp (tcw_pkg::out_resp_t)
//
// A put request passes through S_IDLE and S_FIN, a read request also through S_READ (for the registered RAM read).
// A put that scrolls also passes through S_SCROLL, where the screen RAM moves
// one cell a cycle through its single read and single write port.
// After reset a clearing pass writes zero to all ROWS*COLUMNS cells before the
// first request is taken; colour writes are taken throughout.
// With out_ready low the result waits in the output register and one further
// request is taken and held until that register frees up.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::in_req_t    in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output tcw_pkg::out_resp_t  out_resp
);

  localparam int CELLS      = ROWS * COLUMNS;
  localparam int SCROLL_LEN = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELLS);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_SCROLL = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t             state;
  logic [AW-1:0]      cnt;
  logic [RW-1:0]      cursor_row;
  logic [CW-1:0]      cursor_col;
  logic [AW-1:0]      row_base;
  logic [7:0]         color_attr;
  logic               rd_ok;
  tcw_pkg::out_resp_t res;

  // Put decode
  logic               accept;
  logic               is_put;
  logic               is_bs;
  logic               col_last;
  logic               row_last;
  logic [AW-1:0]      cur_pos;
  logic [RW-1:0]      cursor_row_next;
  logic [CW-1:0]      cursor_col_next;
  logic [AW-1:0]      row_base_next;
  logic [AW-1:0]      pos_next;
  logic [AW-1:0]      widx;
  logic [7:0]         wch;
  logic               wr;
  logic               scroll;

  // RAM ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [15:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [15:0]        ram_q;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_put   = (in_req.kind == tcw_pkg::KIND_PUT);
  assign is_bs    = (in_req.char_code == tcw_pkg::CH_BACKSPACE);
  assign col_last = (cursor_col == CW'(COLUMNS - 1));
  assign row_last = (cursor_row == RW'(ROWS - 1));
  assign cur_pos  = row_base + AW'(cursor_col);

  // Cursor movement for a put request
  always_comb begin
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    row_base_next   = row_base;
    wr              = 1'b0;
    wch             = in_req.char_code;
    scroll          = 1'b0;
    if (in_req.char_code == tcw_pkg::CH_LINE_FEED) begin
      cursor_col_next = '0;
      if (row_last) begin
        scroll = 1'b1;
      end else begin
        cursor_row_next = cursor_row + RW'(1);
        row_base_next   = row_base + AW'(COLUMNS);
      end
    end else if (is_bs) begin
      // nothing to do at the origin
      if (cursor_col != '0 || cursor_row != '0) begin
        wr  = 1'b1;
        wch = tcw_pkg::CH_SPACE;
        if (cursor_col == '0) begin
          cursor_col_next = CW'(COLUMNS - 1);
          cursor_row_next = cursor_row - RW'(1);
          row_base_next   = row_base - AW'(COLUMNS);
        end else begin
          cursor_col_next = cursor_col - CW'(1);
        end
      end
    end else begin
      wr = 1'b1;
      if (col_last) begin
        cursor_col_next = '0;
        if (row_last) begin
          scroll = 1'b1;
        end else begin
          cursor_row_next = cursor_row + RW'(1);
          row_base_next   = row_base + AW'(COLUMNS);
        end
      end else begin
        cursor_col_next = cursor_col + CW'(1);
      end
    end
  end

  assign pos_next = row_base_next + AW'(cursor_col_next);
  // backspace blanks the cell it lands on, a printable byte goes at the old cursor
  assign widx     = is_bs ? pos_next : cur_pos;

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    ram_raddr = cnt + AW'(COLUMNS);
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_we    = accept && is_put && wr;
        ram_waddr = widx;
        ram_wdata = {color_attr, wch};
        ram_raddr = AW'(in_req.read_index);
      end
      S_SCROLL: begin
        // read one row ahead, write back the cell read last cycle
        ram_we    = (cnt != '0);
        ram_waddr = cnt - AW'(1);
        ram_wdata = ram_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Colour attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      color_attr <= tcw_pkg::ATTR_RESET;
    end else if (cfg_write) begin
      color_attr <= cfg_data;
    end
  end

  // Sequencer, cursor and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
      row_base   <= '0;
      out_valid  <= 1'b0;
    end else begin
      // result taken; S_FIN refills the register itself
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cnt == AW'(CELLS - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            res.read_data <= '0;
            if (is_put) begin
              cursor_row       <= cursor_row_next;
              cursor_col       <= cursor_col_next;
              row_base         <= row_base_next;
              res.cursor_pos   <= 11'(pos_next);
              res.cell_written <= wr;
              res.write_index  <= wr ? 11'(widx) : '0;
              res.write_entry  <= wr ? {color_attr, wch} : '0;
              res.scrolled     <= scroll;
              cnt              <= '0;
              state            <= scroll ? S_SCROLL : S_FIN;
            end else begin
              rd_ok            <= (32'(in_req.read_index) < 32'(CELLS));
              res.cursor_pos   <= 11'(cur_pos);
              res.cell_written <= 1'b0;
              res.write_index  <= '0;
              res.write_entry  <= '0;
              res.scrolled     <= 1'b0;
              state            <= S_READ;
            end
          end
        end
        S_READ: begin
          res.read_data <= rd_ok ? ram_q : '0;
          state         <= S_FIN;
        end
        S_SCROLL: begin
          if (cnt == AW'(SCROLL_LEN)) begin
            cnt   <= '0;
            state <= S_FIN;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_resp  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
